### src/sed_pkg.sv
// Shared codes, constants and control structures of the STX/ETX response deframer.
package sed_pkg;

    localparam logic [7:0] STX_CODE = 8'h02;
    localparam logic [7:0] ETX_CODE = 8'h03;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_BADSUM  = 3'd1;
    localparam logic [2:0] ST_LONG    = 3'd2;
    localparam logic [2:0] ST_TIMEOUT = 3'd3;
    localparam logic [2:0] ST_NOSUM   = 3'd4;
    localparam logic [2:0] ST_SHORT   = 3'd5;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERALL_TIMEOUT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECKSUM_WAIT   = 1'd1;

    localparam logic [15:0] OVERALL_TIMEOUT_RESET = 16'd500;
    localparam logic [15:0] CHECKSUM_WAIT_RESET   = 16'd50;
    localparam logic [15:0] ELAPSED_MAX           = 16'hFFFF;

    // Store slot of the first payload byte, and the smallest fill that holds
    // STX, both command bytes and ETX.
    localparam int PAYLOAD_BASE = 3;
    localparam int MIN_FILL     = 4;

    typedef struct packed {
        logic       clr_elapsed;
        logic       inc_elapsed;
        logic       start_frame;
        logic       store_byte;
        logic       set_pend;
        logic [2:0] pend_code;
        logic       pay_start;
        logic       load_single;
        logic       load_pay;
    } sed_cmd_t;

    typedef struct packed {
        logic is_stx;
        logic is_etx;
        logic fill_full;
        logic expire_overall;
        logic expire_csum;
        logic frame_short;
        logic sum_ok;
        logic pay_empty;
        logic pay_last;
        logic out_free;
    } sed_stat_t;

endpackage

### src/sed_in_if.sv
// Input channel: received bytes and millisecond ticks.
interface sed_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] rx_byte;

    modport source (output valid, output op, output rx_byte, input ready);
    modport sink (input valid, input op, input rx_byte, output ready);
endinterface

### src/sed_out_if.sv
// Output channel: status and payload results of a deframed response.
interface sed_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [7:0] cmd_first;
    logic [7:0] cmd_second;
    logic [7:0] data_byte;
    logic       data_valid;
    logic [3:0] data_count;
    logic       last;

    modport source (output valid, output status, output cmd_first, output cmd_second,
                    output data_byte, output data_valid, output data_count,
                    output last, input ready);
    modport sink (input valid, input status, input cmd_first, input cmd_second,
                  input data_byte, input data_valid, input data_count,
                  input last, output ready);
endinterface

### src/sed_ctrl.sv
// Controller: frame phase tracking and result sequencing.
module sed_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_op,
    output logic               in_ready,
    input  sed_pkg::sed_stat_t stat,
    output sed_pkg::sed_cmd_t  cmd
);

    localparam logic [1:0] C_RUN    = 2'd0;
    localparam logic [1:0] C_SINGLE = 2'd1;
    localparam logic [1:0] C_PAY    = 2'd2;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_HUNT = 2'd1;
    localparam logic [1:0] PH_BODY = 2'd2;
    localparam logic [1:0] PH_CSUM = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic [1:0] phase_reg;
    logic [1:0] phase_next;
    logic       accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_RUN;
            phase_reg <= PH_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    assign in_ready = (state_reg == C_RUN);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        cmd        = '0;
        case (state_reg)
            C_RUN:
            begin
                if (accept && in_op)
                begin
                    if (phase_reg != PH_IDLE)
                    begin
                        cmd.inc_elapsed = 1'b1;
                        if (phase_reg == PH_CSUM && stat.expire_csum)
                        begin
                            cmd.set_pend  = 1'b1;
                            cmd.pend_code = sed_pkg::ST_NOSUM;
                            phase_next    = PH_IDLE;
                            state_next    = C_SINGLE;
                        end
                        else if (phase_reg != PH_CSUM && stat.expire_overall)
                        begin
                            cmd.set_pend  = 1'b1;
                            cmd.pend_code = sed_pkg::ST_TIMEOUT;
                            phase_next    = PH_IDLE;
                            state_next    = C_SINGLE;
                        end
                    end
                end
                else if (accept)
                begin
                    case (phase_reg)
                        PH_IDLE, PH_HUNT:
                        begin
                            // The first byte of a frame starts the overall timer.
                            cmd.clr_elapsed = (phase_reg == PH_IDLE);
                            phase_next      = PH_HUNT;
                            if (stat.is_stx)
                            begin
                                cmd.start_frame = 1'b1;
                                phase_next      = PH_BODY;
                            end
                        end
                        PH_BODY:
                        begin
                            if (stat.fill_full)
                            begin
                                cmd.set_pend  = 1'b1;
                                cmd.pend_code = sed_pkg::ST_LONG;
                                phase_next    = PH_IDLE;
                                state_next    = C_SINGLE;
                            end
                            else
                            begin
                                cmd.store_byte = 1'b1;
                                if (stat.is_etx)
                                begin
                                    cmd.clr_elapsed = 1'b1;
                                    phase_next      = PH_CSUM;
                                end
                            end
                        end
                        PH_CSUM:
                        begin
                            phase_next = PH_IDLE;
                            if (stat.frame_short)
                            begin
                                cmd.set_pend  = 1'b1;
                                cmd.pend_code = sed_pkg::ST_SHORT;
                                state_next    = C_SINGLE;
                            end
                            else if (!stat.sum_ok)
                            begin
                                cmd.set_pend  = 1'b1;
                                cmd.pend_code = sed_pkg::ST_BADSUM;
                                state_next    = C_SINGLE;
                            end
                            else if (stat.pay_empty)
                            begin
                                cmd.set_pend  = 1'b1;
                                cmd.pend_code = sed_pkg::ST_OK;
                                state_next    = C_SINGLE;
                            end
                            else
                            begin
                                cmd.pay_start = 1'b1;
                                state_next    = C_PAY;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
            end
            C_SINGLE:
            begin
                if (stat.out_free)
                begin
                    cmd.load_single = 1'b1;
                    state_next      = C_RUN;
                end
            end
            C_PAY:
            begin
                if (stat.out_free)
                begin
                    cmd.load_pay = 1'b1;
                    if (stat.pay_last)
                    begin
                        state_next = C_RUN;
                    end
                end
            end
            default:
            begin
                state_next = C_RUN;
            end
        endcase
    end

endmodule

### src/sed_datapath.sv
// Datapath: timers, frame store, running checksum and output register.
module sed_datapath
#(
    parameter int FRAME_BYTES = 16
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  sed_pkg::sed_cmd_t                     cmd,
    output sed_pkg::sed_stat_t                    stat,
    input  logic [7:0]                            rx_byte,
    input  logic                                  cfg_we,
    input  logic [sed_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [15:0]                           cfg_wdata,
    input  logic                                  out_ready,
    output logic                                  out_valid,
    output logic [2:0]                            out_status,
    output logic [7:0]                            out_cmd_first,
    output logic [7:0]                            out_cmd_second,
    output logic [7:0]                            out_data_byte,
    output logic                                  out_data_valid,
    output logic [3:0]                            out_data_count,
    output logic                                  out_last
);

    localparam int AW = $clog2(FRAME_BYTES);
    localparam logic [AW-1:0] FULL_FILL = AW'(FRAME_BYTES - 2);
    localparam logic [AW-1:0] MIN_FILL  = AW'(sed_pkg::MIN_FILL);
    localparam logic [AW-1:0] PAY_BASE  = AW'(sed_pkg::PAYLOAD_BASE);

    logic [15:0]   overall_reg;
    logic [15:0]   csum_wait_reg;
    logic [15:0]   elapsed_reg;
    logic [15:0]   elapsed_inc;
    logic [AW-1:0] fill_reg;
    logic [7:0]    xor_reg;
    logic [7:0]    cmd1_reg;
    logic [7:0]    cmd2_reg;
    logic [2:0]    pend_reg;
    logic [AW-1:0] idx_reg;
    logic [AW-1:0] idx_next;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] pay_cnt;
    logic [7:0]    q_reg;
    logic [7:0]    mem [FRAME_BYTES];

    logic       out_valid_reg;
    logic [2:0] out_status_reg;
    logic [7:0] out_cmd1_reg;
    logic [7:0] out_cmd2_reg;
    logic [7:0] out_data_reg;
    logic       out_dvalid_reg;
    logic [3:0] out_count_reg;
    logic       out_last_reg;

    assign elapsed_inc = (elapsed_reg == sed_pkg::ELAPSED_MAX) ? elapsed_reg
                                                                 : elapsed_reg + 16'd1;
    assign pay_cnt     = fill_reg - MIN_FILL;

    assign stat.is_stx         = (rx_byte == sed_pkg::STX_CODE);
    assign stat.is_etx         = (rx_byte == sed_pkg::ETX_CODE);
    assign stat.fill_full      = (fill_reg >= FULL_FILL);
    assign stat.expire_overall = (elapsed_inc >= overall_reg);
    assign stat.expire_csum    = (elapsed_inc >= csum_wait_reg);
    assign stat.frame_short    = (fill_reg < MIN_FILL);
    assign stat.sum_ok         = (rx_byte == xor_reg);
    assign stat.pay_empty      = (fill_reg == MIN_FILL);
    assign stat.pay_last       = (idx_reg == pay_cnt - AW'(1));
    assign stat.out_free       = !out_valid_reg || out_ready;

    // The read address runs one entry ahead whenever a payload byte is loaded,
    // so the registered read data always holds the byte for the current index.
    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.pay_start)
        begin
            idx_next = '0;
        end
        else if (cmd.load_pay)
        begin
            idx_next = idx_reg + AW'(1);
        end
    end

    assign rd_addr = idx_next + PAY_BASE;

    always_ff @(posedge clk)
    begin
        if (cmd.store_byte)
        begin
            mem[fill_reg] <= rx_byte;
        end
        q_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            overall_reg   <= sed_pkg::OVERALL_TIMEOUT_RESET;
            csum_wait_reg <= sed_pkg::CHECKSUM_WAIT_RESET;
            elapsed_reg   <= '0;
            fill_reg      <= '0;
            xor_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == sed_pkg::CFG_OVERALL_TIMEOUT)
            begin
                overall_reg <= cfg_wdata;
            end
            if (cfg_we && cfg_index == sed_pkg::CFG_CHECKSUM_WAIT)
            begin
                csum_wait_reg <= cfg_wdata;
            end
            if (cmd.clr_elapsed)
            begin
                elapsed_reg <= '0;
            end
            else if (cmd.inc_elapsed)
            begin
                elapsed_reg <= elapsed_inc;
            end
            if (cmd.start_frame)
            begin
                fill_reg <= AW'(1);
                xor_reg  <= '0;
            end
            else if (cmd.store_byte)
            begin
                fill_reg <= fill_reg + AW'(1);
                xor_reg  <= xor_reg ^ rx_byte;
            end
            idx_reg <= idx_next;
            if (cmd.load_single || cmd.load_pay)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store_byte && fill_reg == AW'(1))
        begin
            cmd1_reg <= rx_byte;
        end
        if (cmd.store_byte && fill_reg == AW'(2))
        begin
            cmd2_reg <= rx_byte;
        end
        if (cmd.set_pend)
        begin
            pend_reg <= cmd.pend_code;
        end
        if (cmd.load_single)
        begin
            out_status_reg <= pend_reg;
            out_cmd1_reg   <= (pend_reg == sed_pkg::ST_OK) ? cmd1_reg : 8'd0;
            out_cmd2_reg   <= (pend_reg == sed_pkg::ST_OK) ? cmd2_reg : 8'd0;
            out_data_reg   <= 8'd0;
            out_dvalid_reg <= 1'b0;
            out_count_reg  <= 4'd0;
            out_last_reg   <= 1'b1;
        end
        else if (cmd.load_pay)
        begin
            out_status_reg <= sed_pkg::ST_OK;
            out_cmd1_reg   <= cmd1_reg;
            out_cmd2_reg   <= cmd2_reg;
            out_data_reg   <= q_reg;
            out_dvalid_reg <= 1'b1;
            out_count_reg  <= 4'(pay_cnt);
            out_last_reg   <= stat.pay_last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_status     = out_status_reg;
    assign out_cmd_first  = out_cmd1_reg;
    assign out_cmd_second = out_cmd2_reg;
    assign out_data_byte  = out_data_reg;
    assign out_data_valid = out_dvalid_reg;
    assign out_data_count = out_count_reg;
    assign out_last       = out_last_reg;

endmodule

### src/stx_etx_response_deframer.sv
// Top level of the STX/ETX response deframer with XOR block check.
// A byte or tick that yields no result leaves the input ready; the next is taken right after.
// A failing or empty frame yields its one result via the pending status and output registers.
// A good frame streams one payload result per cycle, while the output is free, from the
// frame store's registered read port; no input is taken until its last result is loaded.
// Reset clears the controller, timers and output valid; the frame store is not cleared.
module stx_etx_response_deframer
#(
    parameter int FRAME_BYTES = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    sed_in_if.sink                        rx_chan,
    sed_out_if.source                     rsp_chan,
    input  logic                          cfg_we,
    input  logic [sed_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                   cfg_wdata
);

    sed_pkg::sed_cmd_t  cmd;
    sed_pkg::sed_stat_t stat;

    sed_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rx_chan.valid),
        .in_op    (rx_chan.op),
        .in_ready (rx_chan.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sed_datapath #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .rx_byte        (rx_chan.rx_byte),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .out_ready      (rsp_chan.ready),
        .out_valid      (rsp_chan.valid),
        .out_status     (rsp_chan.status),
        .out_cmd_first  (rsp_chan.cmd_first),
        .out_cmd_second (rsp_chan.cmd_second),
        .out_data_byte  (rsp_chan.data_byte),
        .out_data_valid (rsp_chan.data_valid),
        .out_data_count (rsp_chan.data_count),
        .out_last       (rsp_chan.last)
    );

`ifndef SYNTH
    // Only a payload run has results that are not the last one.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_chan.valid && !rsp_chan.last
        |-> rsp_chan.status == sed_pkg::ST_OK && rsp_chan.data_valid)
        else $error("non-final result outside a payload run");

    // An error result carries no frame content and ends the run.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_chan.valid && rsp_chan.status != sed_pkg::ST_OK
        |-> rsp_chan.cmd_first == 8'd0 && rsp_chan.cmd_second == 8'd0
            && !rsp_chan.data_valid && rsp_chan.data_count == 4'd0 && rsp_chan.last)
        else $error("error result carries frame content");

    // No input transaction is taken while a result sequence is being produced.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_single || cmd.load_pay) |-> !rx_chan.ready)
        else $error("input taken while results are pending");
`endif

endmodule
